// ----- hdl/klx_pkg.sv -----
// Shared types, token kinds and character classes for the keyword lexer.
// No dependencies; used by every module of the block and by its checker.
package klx_pkg;

  // Token kinds
  localparam logic [5:0] KIND_PLUS   = 6'd0;
  localparam logic [5:0] KIND_MINUS  = 6'd1;
  localparam logic [5:0] KIND_STAR   = 6'd2;
  localparam logic [5:0] KIND_SLASH  = 6'd3;
  localparam logic [5:0] KIND_PCT    = 6'd4;
  localparam logic [5:0] KIND_COMMA  = 6'd5;
  localparam logic [5:0] KIND_COLON  = 6'd6;
  localparam logic [5:0] KIND_SEMI   = 6'd7;
  localparam logic [5:0] KIND_AMP    = 6'd8;
  localparam logic [5:0] KIND_LPAR   = 6'd9;
  localparam logic [5:0] KIND_RPAR   = 6'd10;
  localparam logic [5:0] KIND_LBRACE = 6'd11;
  localparam logic [5:0] KIND_RBRACE = 6'd12;
  localparam logic [5:0] KIND_QUEST  = 6'd13;
  localparam logic [5:0] KIND_NE     = 6'd14;
  localparam logic [5:0] KIND_BANG   = 6'd15;
  localparam logic [5:0] KIND_EQEQ   = 6'd16;
  localparam logic [5:0] KIND_ASSIGN = 6'd17;
  localparam logic [5:0] KIND_GE     = 6'd18;
  localparam logic [5:0] KIND_GT     = 6'd19;
  localparam logic [5:0] KIND_LE     = 6'd20;
  localparam logic [5:0] KIND_LT     = 6'd21;
  localparam logic [5:0] KIND_KW0    = 6'd22;
  localparam logic [5:0] KIND_IDENT  = 6'd35;
  localparam logic [5:0] KIND_INT    = 6'd36;
  localparam logic [5:0] KIND_FLOAT  = 6'd37;
  localparam logic [5:0] KIND_STRING = 6'd38;
  localparam logic [5:0] KIND_END    = 6'd39;

  localparam int WORD_DEPTH   = 7;
  localparam int NUM_KEYWORDS = 13;
  localparam int MAX_TOKENS   = 4;

  // Keywords left-aligned, zero padded: first character in the top byte.
  localparam logic [55:0] KW_TEXT [NUM_KEYWORDS] = '{
    {"builtin"}, {"proc", 24'h0}, {"if", 40'h0}, {"else", 24'h0},
    {"for", 32'h0}, {"while", 16'h0}, {"var", 32'h0}, {"type", 24'h0},
    {"struct", 8'h0}, {"enum", 24'h0}, {"int", 32'h0}, {"float", 16'h0},
    {"bool", 24'h0}
  };
  localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
    3'd7, 3'd4, 3'd2, 3'd4, 3'd3, 3'd5, 3'd3, 3'd4, 3'd6, 3'd4, 3'd3, 3'd5, 3'd4
  };

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_OPER   = 6'b000010,
    MODE_IDENT  = 6'b000100,
    MODE_INT    = 6'b001000,
    MODE_FLOAT  = 6'b010000,
    MODE_STRING = 6'b100000
  } lex_mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        unterm;
  } token_t;

  typedef struct packed {
    token_t [MAX_TOKENS-1:0] tok;
    logic [2:0]              count;
  } bundle_t;

  function automatic token_t mk_tok(input logic [5:0] kind, input logic [15:0] start,
                                    input logic [15:0] length, input logic unterm);
    token_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = length;
    t.unterm = unterm;
    return t;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_numeral(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_pair_lead(input logic [7:0] b);
    return b == "!" || b == "=" || b == ">" || b == "<";
  endfunction

  // Kind of a one-byte operator; valid flag in the top bit.
  function automatic logic [6:0] single_kind(input logic [7:0] b);
    logic [6:0] r;
    r = 7'd0;
    case (b)
      "+": r = {1'b1, KIND_PLUS};
      "-": r = {1'b1, KIND_MINUS};
      "*": r = {1'b1, KIND_STAR};
      "/": r = {1'b1, KIND_SLASH};
      "%": r = {1'b1, KIND_PCT};
      ",": r = {1'b1, KIND_COMMA};
      ":": r = {1'b1, KIND_COLON};
      ";": r = {1'b1, KIND_SEMI};
      "&": r = {1'b1, KIND_AMP};
      "(": r = {1'b1, KIND_LPAR};
      ")": r = {1'b1, KIND_RPAR};
      "{": r = {1'b1, KIND_LBRACE};
      "}": r = {1'b1, KIND_RBRACE};
      "?": r = {1'b1, KIND_QUEST};
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  // Lone form of ! = > < ; the two-byte form with '=' is one less.
  function automatic logic [5:0] lone_kind(input logic [7:0] b);
    logic [5:0] r;
    case (b)
      "!": r = KIND_BANG;
      "=": r = KIND_ASSIGN;
      ">": r = KIND_GT;
      default: r = KIND_LT;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] word_kind(input logic [55:0] w, input logic [15:0] len);
    logic [5:0] r;
    r = KIND_IDENT;
    for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
      if (len == 16'(KW_LEN[k]) && w == KW_TEXT[k]) begin
        r = KIND_KW0 + 6'(k);
      end
    end
    return r;
  endfunction

endpackage

// ----- hdl/klx_core.sv -----
// Lexer state and next-token logic: classifies one byte against the open token.
// Depends on klx_pkg. Produces a bundle of up to four tokens per byte.
module klx_core
  import klx_pkg::*;
#(
  parameter int TEXT_MAX = 65536
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic [7:0] b,
  input  logic       fin,
  output bundle_t    bundle
);

  localparam int POS_W = $clog2(TEXT_MAX);

  lex_mode_t         mode, mode_next;
  logic [POS_W-1:0]  pos, pos_next, pos_inc;
  logic [POS_W-1:0]  origin, origin_next;
  logic [7:0]        pend, pend_next;
  logic [0:6][7:0]   wbuf, wbuf_next;
  logic [15:0]       wl, wl_next, wl_sat;

  function automatic logic [15:0] low16(input logic [POS_W-1:0] p);
    logic [POS_W+15:0] e;
    e = {16'b0, p};
    return e[15:0];
  endfunction

  assign pos_inc = (pos == POS_W'(TEXT_MAX - 1)) ? '0 : pos + 1'b1;
  assign wl_sat  = (wl == 16'hFFFF) ? wl : wl + 16'd1;

  always_comb begin
    logic       taken;
    logic [2:0] n;
    logic [6:0] sk;
    bundle_t    r;
    r           = '0;
    n           = 3'd0;
    taken       = 1'b0;
    sk          = single_kind(b);
    mode_next   = mode;
    pos_next    = pos_inc;
    origin_next = origin;
    pend_next   = pend;
    wbuf_next   = wbuf;
    wl_next     = wl;

    // Close or extend the open token
    unique case (mode)
      MODE_OPER: begin
        if (b == "=") begin
          r.tok[n[1:0]] = mk_tok(lone_kind(pend) - 6'd1, low16(origin), 16'd2, 1'b0);
          taken = 1'b1;
        end else begin
          r.tok[n[1:0]] = mk_tok(lone_kind(pend), low16(origin), 16'd1, 1'b0);
        end
        n = n + 3'd1;
        mode_next = MODE_IDLE;
      end
      MODE_IDENT: begin
        if (is_letter(b) || is_numeral(b)) begin
          for (int i = 0; i < WORD_DEPTH; i++) begin
            if (wl == 16'(i)) wbuf_next[i] = b;
          end
          wl_next = wl_sat;
          taken = 1'b1;
        end else begin
          r.tok[n[1:0]] = mk_tok(word_kind(wbuf, wl), low16(origin), wl, 1'b0);
          n = n + 3'd1;
          mode_next = MODE_IDLE;
        end
      end
      MODE_INT: begin
        if (is_numeral(b) || b == ".") begin
          if (b == ".") mode_next = MODE_FLOAT;
          wl_next = wl_sat;
          taken = 1'b1;
        end else begin
          r.tok[n[1:0]] = mk_tok(KIND_INT, low16(origin), wl, 1'b0);
          n = n + 3'd1;
          mode_next = MODE_IDLE;
        end
      end
      MODE_FLOAT: begin
        if (is_numeral(b)) begin
          wl_next = wl_sat;
          taken = 1'b1;
        end else begin
          r.tok[n[1:0]] = mk_tok(KIND_FLOAT, low16(origin), wl, 1'b0);
          n = n + 3'd1;
          mode_next = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (b == "\"") begin
          r.tok[n[1:0]] = mk_tok(KIND_STRING, low16(origin), wl, 1'b0);
          n = n + 3'd1;
          mode_next = MODE_IDLE;
        end else begin
          wl_next = wl_sat;
        end
        taken = 1'b1;
      end
      default: mode_next = MODE_IDLE;
    endcase

    // Start a new token with this byte
    if (!taken) begin
      if (sk[6]) begin
        r.tok[n[1:0]] = mk_tok(sk[5:0], low16(pos), 16'd1, 1'b0);
        n = n + 3'd1;
      end else if (is_pair_lead(b)) begin
        mode_next   = MODE_OPER;
        pend_next   = b;
        origin_next = pos;
      end else if (is_letter(b)) begin
        mode_next    = MODE_IDENT;
        origin_next  = pos;
        wbuf_next    = '0;
        wbuf_next[0] = b;
        wl_next      = 16'd1;
      end else if (is_numeral(b)) begin
        mode_next   = MODE_INT;
        origin_next = pos;
        wl_next     = 16'd1;
      end else if (b == "\"") begin
        mode_next   = MODE_STRING;
        origin_next = pos_inc;
        wl_next     = 16'd0;
      end
    end

    // End of text: flush the open token, add two END items, start over
    if (fin) begin
      unique case (mode_next)
        MODE_OPER: begin
          r.tok[n[1:0]] = mk_tok(lone_kind(pend_next), low16(origin_next), 16'd1, 1'b0);
          n = n + 3'd1;
        end
        MODE_IDENT: begin
          r.tok[n[1:0]] = mk_tok(word_kind(wbuf_next, wl_next), low16(origin_next),
                                 wl_next, 1'b0);
          n = n + 3'd1;
        end
        MODE_INT: begin
          r.tok[n[1:0]] = mk_tok(KIND_INT, low16(origin_next), wl_next, 1'b0);
          n = n + 3'd1;
        end
        MODE_FLOAT: begin
          r.tok[n[1:0]] = mk_tok(KIND_FLOAT, low16(origin_next), wl_next, 1'b0);
          n = n + 3'd1;
        end
        MODE_STRING: begin
          r.tok[n[1:0]] = mk_tok(KIND_STRING, low16(origin_next), wl_next, 1'b1);
          n = n + 3'd1;
        end
        default: ;
      endcase
      r.tok[n[1:0]] = mk_tok(KIND_END, low16(pos_inc), 16'd0, 1'b0);
      n = n + 3'd1;
      r.tok[n[1:0]] = mk_tok(KIND_END, low16(pos_inc), 16'd0, 1'b0);
      n = n + 3'd1;
      mode_next   = MODE_IDLE;
      pos_next    = '0;
      origin_next = '0;
      pend_next   = 8'd0;
      wbuf_next   = '0;
      wl_next     = 16'd0;
    end

    r.count = n;
    bundle  = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      pos    <= '0;
      origin <= '0;
      pend   <= 8'd0;
      wbuf   <= '0;
      wl     <= 16'd0;
    end else if (adv) begin
      mode   <= mode_next;
      pos    <= pos_next;
      origin <= origin_next;
      pend   <= pend_next;
      wbuf   <= wbuf_next;
      wl     <= wl_next;
    end
  end

endmodule

// ----- hdl/klx_out.sv -----
// Token register: holds one byte's bundle of tokens and hands them out in order.
// Depends on klx_pkg.
module klx_out
  import klx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  bundle_t     bundle,
  output logic        free,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [5:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic        unterminated,
  output logic        run_last
);

  logic                    held;
  logic [1:0]              idx;
  logic [1:0]              last_idx;
  token_t [MAX_TOKENS-1:0] toks;
  logic                    at_last;
  token_t                  cur;

  assign at_last = (idx == last_idx);
  assign free    = !held || (token_ready && at_last);
  assign cur     = toks[idx];

  assign token_valid  = held;
  assign token_kind   = cur.kind;
  assign token_start  = cur.start;
  assign token_length = cur.length;
  assign unterminated = cur.unterm;
  assign run_last     = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= 2'd0;
    end else if (held && token_ready && !at_last) begin
      idx <= idx + 2'd1;
    end else if (free) begin
      held <= load;
      idx  <= 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      toks     <= bundle.tok;
      last_idx <= 2'(bundle.count - 3'd1);
    end
  end

endmodule

// ----- hdl/keyword_lexer_unit.sv -----
// Streaming keyword lexer: one text byte in per cycle, tokens out as kind, start, length.
// A byte that yields no token or one token is taken every cycle while token_ready holds;
// a byte that yields more (up to four, at most on the final byte) holds the input until
// its last token is taken; the token register hands out one token per cycle of token_ready.
// The first token of a byte goes through the input register, then the token register.
// Depends on klx_pkg, klx_core and klx_out.
module keyword_lexer_unit
  import klx_pkg::*;
#(
  parameter int TEXT_MAX = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_ready,
  input  logic [7:0]  text_byte,
  input  logic        final_byte,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [5:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic        unterminated,
  output logic        run_last
);

  logic       in_held;
  logic [7:0] in_byte;
  logic       in_fin;
  logic       adv;
  logic       free;
  bundle_t    bundle;

  assign adv        = in_held && free;
  assign text_ready = !in_held || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (text_ready) begin
      in_held <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && text_ready) begin
      in_byte <= text_byte;
      in_fin  <= final_byte;
    end
  end

  klx_core #(.TEXT_MAX(TEXT_MAX)) u_core (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .b      (in_byte),
    .fin    (in_fin),
    .bundle (bundle)
  );

  klx_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (adv && bundle.count != 3'd0),
    .bundle       (bundle),
    .free         (free),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .unterminated (unterminated),
    .run_last     (run_last)
  );

endmodule

// ----- hdl/klx_checker.sv -----
// Port-level checks for the keyword lexer, bound to keyword_lexer_unit.
// Depends on klx_pkg.
module klx_checker
  import klx_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        token_valid,
  input logic        token_ready,
  input logic [5:0]  token_kind,
  input logic [15:0] token_length,
  input logic        unterminated
);

  // A stalled token holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_ready |=> token_valid && $stable(token_kind)
                                     && $stable(token_length))
    else $error("stalled token changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !token_valid)
    else $error("token shown right after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> token_kind <= KIND_END)
    else $error("token kind out of range");

  a_unterm_string: assert property (@(posedge clk) disable iff (rst)
    token_valid && unterminated |-> token_kind == KIND_STRING)
    else $error("unterminated flag on a non-string token");

  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_kind == KIND_END |-> token_length == 16'd0)
    else $error("END token with nonzero length");

endmodule

bind keyword_lexer_unit klx_checker u_klx_checker (
  .clk          (clk),
  .rst          (rst),
  .token_valid  (token_valid),
  .token_ready  (token_ready),
  .token_kind   (token_kind),
  .token_length (token_length),
  .unterminated (unterminated)
);

// ----- verif/keyword_lexer_unit_test.sv -----
// Self-checking bench for keyword_lexer_unit: streams source text in byte by byte and
// checks every token against a lexer model kept inside the bench.
// Depends on klx_pkg (token kinds, lexer mode enum) and the keyword_lexer_unit RTL.
module keyword_lexer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import klx_pkg::*;

  localparam int TOKENS_PER_BYTE = 4;
  localparam int WORD_KEEP       = 7;
  localparam int KEYWORD_COUNT   = 13;
  localparam int REPORT_LIMIT    = 10;
  localparam int HOLD_CYCLES     = 200;
  localparam int SETTLE_CYCLES   = 16;
  localparam int RANDOM_ITEMS    = 16;

  // Receiver stall styles
  localparam int RX_READY   = 0;
  localparam int RX_COIN    = 1;
  localparam int RX_PATTERN = 2;
  localparam int RX_MOSTLY  = 3;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        unterm;
    logic        last;
  } lex_token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic [7:0]  text_byte = 8'h00;
  logic        final_byte = 1'b0;
  logic        token_ready = 1'b0;
  logic        text_ready;
  logic        token_valid;
  logic [5:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        unterminated;
  logic        run_last;

  keyword_lexer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_byte    (text_byte),
    .final_byte   (final_byte),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .unterminated (unterminated),
    .run_last     (run_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Lexer model state
  lex_mode_t   lx_mode;
  logic [15:0] lx_pos;
  logic [15:0] lx_origin;
  logic [15:0] lx_len;
  logic [7:0]  lx_pend;
  logic [7:0]  lx_word [WORD_KEEP];
  lex_token_t  byte_tokens [TOKENS_PER_BYTE];
  int          byte_token_n;
  lex_token_t  lexed_tokens [$];

  int fail_count  = 0;
  int burst_left  = 0;
  bit steady_send = 1'b0;
  int rx_style    = RX_READY;
  bit hold_request = 1'b0;
  int hold_left   = 0;
  int rx_phase    = 0;

  function automatic string keyword_text(input int k);
    case (k)
      0:  return "builtin";
      1:  return "proc";
      2:  return "if";
      3:  return "else";
      4:  return "for";
      5:  return "while";
      6:  return "var";
      7:  return "type";
      8:  return "struct";
      9:  return "enum";
      10: return "int";
      11: return "float";
      default: return "bool";
    endcase
  endfunction

  function automatic bit word_lead(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic bit dec_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic int single_op(input logic [7:0] b);
    case (b)
      "+": return int'(KIND_PLUS);
      "-": return int'(KIND_MINUS);
      "*": return int'(KIND_STAR);
      "/": return int'(KIND_SLASH);
      "%": return int'(KIND_PCT);
      ",": return int'(KIND_COMMA);
      ":": return int'(KIND_COLON);
      ";": return int'(KIND_SEMI);
      "&": return int'(KIND_AMP);
      "(": return int'(KIND_LPAR);
      ")": return int'(KIND_RPAR);
      "{": return int'(KIND_LBRACE);
      "}": return int'(KIND_RBRACE);
      "?": return int'(KIND_QUEST);
      default: return -1;
    endcase
  endfunction

  // Lone form; the form followed by '=' is one kind lower.
  function automatic logic [5:0] lone_op(input logic [7:0] b);
    case (b)
      "!": return KIND_BANG;
      "=": return KIND_ASSIGN;
      ">": return KIND_GT;
      default: return KIND_LT;
    endcase
  endfunction

  function automatic logic [5:0] word_kind();
    logic [5:0] found;
    string      kw;
    bit         same;
    int         k;
    int         i;
    found = KIND_IDENT;
    for (k = 0; k < KEYWORD_COUNT; k++) begin
      kw = keyword_text(k);
      if (found == KIND_IDENT && lx_len == 16'(kw.len())) begin
        same = 1'b1;
        for (i = 0; i < kw.len(); i++) begin
          if (lx_word[i] != kw[i]) same = 1'b0;
        end
        if (same) found = KIND_KW0 + 6'(k);
      end
    end
    return found;
  endfunction

  function automatic void clear_lexer();
    lx_mode   = MODE_IDLE;
    lx_pos    = 16'd0;
    lx_origin = 16'd0;
    lx_len    = 16'd0;
    lx_pend   = 8'd0;
    foreach (lx_word[i]) lx_word[i] = 8'd0;
  endfunction

  function automatic void push_token(input logic [5:0] kind, input logic [15:0] start,
                                     input logic [15:0] length, input logic unterm);
    // The block hands out at most four tokens per byte; drop the rest.
    if (byte_token_n < TOKENS_PER_BYTE) begin
      byte_tokens[byte_token_n] = '{kind, start, length, unterm, 1'b0};
      byte_token_n++;
    end
  endfunction

  function automatic void grow_len();
    if (lx_len != 16'hFFFF) lx_len = lx_len + 16'd1;
  endfunction

  function automatic void lex_byte(input logic [7:0] b, input logic fin);
    bit taken;
    int op;
    int i;
    taken = 1'b0;
    byte_token_n = 0;
    case (lx_mode)
      MODE_OPER: begin
        if (b == "=") begin
          push_token(lone_op(lx_pend) - 6'd1, lx_origin, 16'd2, 1'b0);
          taken = 1'b1;
        end else begin
          push_token(lone_op(lx_pend), lx_origin, 16'd1, 1'b0);
        end
        lx_mode = MODE_IDLE;
      end
      MODE_IDENT: begin
        if (word_lead(b) || dec_digit(b)) begin
          if (lx_len < 16'(WORD_KEEP)) lx_word[lx_len[2:0]] = b;
          grow_len();
          taken = 1'b1;
        end else begin
          push_token(word_kind(), lx_origin, lx_len, 1'b0);
          lx_mode = MODE_IDLE;
        end
      end
      MODE_INT: begin
        if (dec_digit(b) || b == ".") begin
          if (b == ".") lx_mode = MODE_FLOAT;
          grow_len();
          taken = 1'b1;
        end else begin
          push_token(KIND_INT, lx_origin, lx_len, 1'b0);
          lx_mode = MODE_IDLE;
        end
      end
      MODE_FLOAT: begin
        if (dec_digit(b)) begin
          grow_len();
          taken = 1'b1;
        end else begin
          push_token(KIND_FLOAT, lx_origin, lx_len, 1'b0);
          lx_mode = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (b == "\"") begin
          push_token(KIND_STRING, lx_origin, lx_len, 1'b0);
          lx_mode = MODE_IDLE;
        end else begin
          grow_len();
        end
        taken = 1'b1;
      end
      default: lx_mode = MODE_IDLE;
    endcase

    if (!taken) begin
      op = single_op(b);
      if (op >= 0) begin
        push_token(6'(op), lx_pos, 16'd1, 1'b0);
      end else if (b == "!" || b == "=" || b == ">" || b == "<") begin
        lx_mode   = MODE_OPER;
        lx_pend   = b;
        lx_origin = lx_pos;
      end else if (word_lead(b)) begin
        lx_mode   = MODE_IDENT;
        lx_origin = lx_pos;
        foreach (lx_word[j]) lx_word[j] = 8'd0;
        lx_word[0] = b;
        lx_len    = 16'd1;
      end else if (dec_digit(b)) begin
        lx_mode   = MODE_INT;
        lx_origin = lx_pos;
        lx_len    = 16'd1;
      end else if (b == "\"") begin
        lx_mode   = MODE_STRING;
        lx_origin = lx_pos + 16'd1;
        lx_len    = 16'd0;
      end
    end

    lx_pos = lx_pos + 16'd1;

    if (fin) begin
      // Flush the open token, then two END markers at the text length.
      case (lx_mode)
        MODE_OPER:   push_token(lone_op(lx_pend), lx_origin, 16'd1, 1'b0);
        MODE_IDENT:  push_token(word_kind(), lx_origin, lx_len, 1'b0);
        MODE_INT:    push_token(KIND_INT, lx_origin, lx_len, 1'b0);
        MODE_FLOAT:  push_token(KIND_FLOAT, lx_origin, lx_len, 1'b0);
        MODE_STRING: push_token(KIND_STRING, lx_origin, lx_len, 1'b1);
        default: ;
      endcase
      push_token(KIND_END, lx_pos, 16'd0, 1'b0);
      push_token(KIND_END, lx_pos, 16'd0, 1'b0);
      clear_lexer();
    end

    if (byte_token_n > 0) byte_tokens[byte_token_n - 1].last = 1'b1;
    for (i = 0; i < byte_token_n; i++) lexed_tokens.push_back(byte_tokens[i]);
  endfunction

  // Receiver: stall per the current style, or hold off entirely on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    rx_phase = rx_phase + 1;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      token_ready <= 1'b0;
    end else begin
      case (rx_style)
        RX_READY:   token_ready <= 1'b1;
        RX_COIN:    token_ready <= 1'($urandom_range(0, 1));
        RX_PATTERN: token_ready <= (rx_phase % 7) > 2;
        default:    token_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    lex_token_t want;
    if (!rst && token_valid && token_ready) begin
      if (lexed_tokens.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected token: kind %0d start %0d length %0d unterm %0b last %0b",
                   token_kind, token_start, token_length, unterminated, run_last);
      end else begin
        want = lexed_tokens.pop_front();
        if (token_kind !== want.kind || token_start !== want.start ||
            token_length !== want.length || unterminated !== want.unterm ||
            run_last !== want.last) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("token mismatch: expected kind %0d start %0d length %0d unterm %0b last %0b",
                     want.kind, want.start, want.length, want.unterm, want.last);
            $display("                got      kind %0d start %0d length %0d unterm %0b last %0b",
                     token_kind, token_start, token_length, unterminated, run_last);
          end
        end
      end
    end
  end

  // Enter and leave at a falling edge; valid stays high for the next call.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = 0;
    if (!steady_send) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_valid <= 1'b1;
    text_byte  <= b;
    final_byte <= fin;
    do @(posedge clk); while (!text_ready);
    lex_byte(b, fin);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // Drop valid and hold until every predicted token has come back.
  task automatic wait_drain();
    text_valid <= 1'b0;
    while (lexed_tokens.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] word_char(input bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  task automatic test_operators();
    rx_style = RX_COIN;
    send_text("+-*/%,:;&(){}?");
    send_text("!===>=<=!<>");
    wait_drain();
  endtask

  task automatic test_keywords();
    rx_style = RX_PATTERN;
    send_text("builtin builtins iff Bool");
    wait_drain();
  endtask

  task automatic test_numbers();
    rx_style = RX_MOSTLY;
    send_text("3.5 7..8 9+");
    wait_drain();
  endtask

  task automatic test_strings();
    rx_style = RX_COIN;
    send_text("\"ab c\"\"\"k\"{x}");
    wait_drain();
  endtask

  // Unknown bytes, whitespace and the byte extremes between tokens.
  task automatic test_skipped_bytes();
    logic [7:0] mix [12];
    int i;
    mix = '{"a", 8'h00, "b", 8'hFF, "1", 8'h80, "#", "\t", "2", 8'h7F, "\n", " "};
    rx_style = RX_READY;
    for (i = 0; i < 12; i++) send_byte(mix[i], i == 11);
    wait_drain();
  endtask

  // Final byte on an open token, on a lone byte, and one that fills all four token slots.
  task automatic test_final_flush();
    rx_style = RX_MOSTLY;
    send_text(" ");
    send_text("<");
    send_text("ab");
    send_text("!a");
    send_text("7.");
    wait_drain();
  endtask

  task automatic test_backpressure();
    int i;
    string ops;
    ops = "(){}+-*/";
    rx_style = RX_READY;
    steady_send = 1'b1;
    @(posedge clk) hold_request = 1'b1;
    @(negedge clk);
    for (i = 0; i < 12; i++) send_byte(ops[i % ops.len()], i == 11);
    wait_drain();
    steady_send = 1'b0;
  endtask

  task automatic test_random_text();
    logic [7:0] txt [$];
    string      kw;
    string      ops;
    int         sent;
    int         target;
    int         n;
    int         i;
    logic [7:0] b;
    ops = "+-*/%,:;&(){}?!=<>";
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      txt.delete();
      steady_send = ($urandom_range(0, 3) == 0);
      rx_style = int'($urandom_range(0, 3));
      target = $urandom_range(6, 12);
      if ($urandom_range(0, 4) == 0) begin
        repeat (target) txt.push_back(8'($urandom_range(0, 255)));
      end else begin
        while (txt.size() < target) begin
          case ($urandom_range(0, 6))
            0: begin
              kw = keyword_text($urandom_range(0, KEYWORD_COUNT - 1));
              for (i = 0; i < kw.len(); i++) txt.push_back(kw[i]);
            end
            1: begin
              n = $urandom_range(1, 10);
              txt.push_back(word_char(1'b1));
              for (i = 1; i < n; i++) txt.push_back(word_char(1'b0));
            end
            2: begin
              n = $urandom_range(1, 5);
              for (i = 0; i < n; i++) txt.push_back(8'("0" + $urandom_range(0, 9)));
            end
            3: begin
              n = $urandom_range(1, 3);
              for (i = 0; i < n; i++) txt.push_back(8'("0" + $urandom_range(0, 9)));
              txt.push_back(".");
              n = $urandom_range(0, 3);
              for (i = 0; i < n; i++) txt.push_back(8'("0" + $urandom_range(0, 9)));
              if ($urandom_range(0, 3) == 0) txt.push_back(".");
            end
            4: begin
              txt.push_back("\"");
              n = $urandom_range(0, 8);
              for (i = 0; i < n; i++) begin
                do b = 8'($urandom_range(0, 255)); while (b == "\"");
                txt.push_back(b);
              end
              // Leave a few strings open to break the sequence.
              if ($urandom_range(0, 7) != 0) txt.push_back("\"");
            end
            5: begin
              txt.push_back(ops[$urandom_range(0, ops.len() - 1)]);
              if ($urandom_range(0, 1) == 0) txt.push_back("=");
            end
            default: begin
              case ($urandom_range(0, 5))
                0: txt.push_back("\t");
                1: txt.push_back("\n");
                2: txt.push_back(8'($urandom_range(128, 255)));
                3: txt.push_back("#");
                4: txt.push_back(8'h00);
                default: txt.push_back(" ");
              endcase
            end
          endcase
          if ($urandom_range(0, 1) == 0) txt.push_back(" ");
        end
      end
      for (i = 0; i < txt.size(); i++) send_byte(txt[i], i == txt.size() - 1);
      sent += txt.size();
    end
    wait_drain();
  endtask

  initial begin
    clear_lexer();
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_operators();
    test_keywords();
    test_numbers();
    test_strings();
    test_skipped_bytes();
    test_final_flush();
    test_backpressure();
    test_random_text();
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #200_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/klx_pkg.sv
hdl/klx_core.sv
hdl/klx_out.sv
hdl/keyword_lexer_unit.sv
hdl/klx_checker.sv
verif/keyword_lexer_unit_test.sv
